/* sv/twt_pkg.sv */
`default_nettype none
package twt_pkg;

  localparam int NODE_POOL_DEF  = 1024;
  localparam int MAX_LENGTH_DEF = 255;
  localparam int ALPHABET       = 26;
  localparam int LANE_W         = 5;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [2:0] FN_INSERT  = 3'd0;
  localparam logic [2:0] FN_SEARCH  = 3'd1;
  localparam logic [2:0] FN_PREFIX  = 3'd2;
  localparam logic [2:0] FN_LONGEST = 3'd3;
  localparam logic [2:0] FN_CLEAR   = 3'd4;

  localparam logic [7:0] CH_A = 8'h61;
  localparam logic [7:0] CH_Z = 8'h7a;

  // one classified item
  typedef struct packed {
    logic [2:0]        func;
    logic              walk;      // letter present and func walks the trie
    logic              bad_char;  // walk with a byte outside a..z
    logic [LANE_W-1:0] lane;
    logic              last;
  } cmd_t;

  typedef struct packed {
    logic        ok;
    logic [7:0]  match_length;
    logic [9:0]  words_stored;
    logic [10:0] nodes_used;
  } res_t;

endpackage
`default_nettype wire

/* sv/twt_front.sv */
`default_nettype none
module twt_front (
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [2:0]    in_func,
  input  wire logic [7:0]    in_letter,
  input  wire logic          in_has_letter,
  input  wire logic          in_last,
  output logic               push,
  output twt_pkg::cmd_t      cmd,
  input  wire logic          q_full
);

  logic is_letter;
  logic [7:0] ofs;

  always_comb begin
    is_letter    = (in_letter >= twt_pkg::CH_A) && (in_letter <= twt_pkg::CH_Z);
    ofs          = in_letter - twt_pkg::CH_A;
    cmd.func     = in_func;
    cmd.walk     = in_has_letter && (in_func <= twt_pkg::FN_LONGEST);
    cmd.bad_char = cmd.walk && !is_letter;
    cmd.lane     = ofs[twt_pkg::LANE_W-1:0];
    cmd.last     = in_last;
    in_ready     = !q_full;
    push         = in_valid && !q_full;
  end

endmodule
`default_nettype wire

/* sv/twt_fifo.sv */
`default_nettype none
module twt_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  twt_pkg::cmd_t      wdata,
  output logic               full,
  input  wire logic          pop,
  output twt_pkg::cmd_t      rdata,
  output logic               not_empty
);

  localparam int AW = $clog2(twt_pkg::QUEUE_DEPTH);

  twt_pkg::cmd_t  slots_r [twt_pkg::QUEUE_DEPTH];
  logic [AW:0]    wp_r, rp_r;

  always_comb begin
    not_empty = (wp_r != rp_r);
    full      = (wp_r[AW-1:0] == rp_r[AW-1:0]) && (wp_r[AW] != rp_r[AW]);
    rdata     = slots_r[rp_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots_r[wp_r[AW-1:0]] <= wdata;
  end

endmodule
`default_nettype wire

/* sv/twt_back.sv */
`default_nettype none
module twt_back #(
  parameter int NODE_POOL  = twt_pkg::NODE_POOL_DEF,
  parameter int MAX_LENGTH = twt_pkg::MAX_LENGTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  twt_pkg::cmd_t  cmd,
  input  wire logic      cmd_valid,
  output logic           cmd_pop,
  output logic           out_valid,
  input  wire logic      out_ready,
  output twt_pkg::res_t  res
);

  localparam int NW  = $clog2(NODE_POOL);
  localparam int NCW = $clog2(NODE_POOL + 1);
  localparam int LW  = $clog2(MAX_LENGTH + 1);
  localparam int EW  = NW + 1;
  localparam int LN  = twt_pkg::ALPHABET;

  localparam logic [1:0] S_CLR  = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  // row of a node: per letter {end flag of child, child index}
  logic [LN-1:0][EW-1:0] mem [NODE_POOL];
  logic [LN-1:0][EW-1:0] row_r;

  logic [1:0]    state_r, state_nxt;
  logic [NW-1:0] sweep_r, sweep_nxt, limit_r, limit_nxt;
  twt_pkg::cmd_t cmd_r;
  logic [NW-1:0] cur_r, cur_nxt, par_r, par_nxt;
  logic          cend_r, cend_nxt, fail_r, fail_nxt;
  logic [twt_pkg::LANE_W-1:0] plane_r, plane_nxt;
  logic [LW-1:0] pos_r, pos_nxt, best_r, best_nxt, pos_inc;
  logic [NCW-1:0] ntot_r, ntot_nxt;
  logic [NW-1:0] wtot_r, wtot_nxt;
  logic          out_valid_r, out_valid_nxt;
  twt_pkg::res_t res_r, res_nxt;

  logic [EW-1:0] entry;
  logic [NW-1:0] next_node;
  logic          next_end, alloc, step, set_end, wr_en, ok;
  logic [31:0]   best32, wt32, nt32;
  logic [7:0]    mlen;
  logic [NW-1:0] wr_row, wr_node;
  logic [twt_pkg::LANE_W-1:0] wr_lane;

  always_comb begin
    cmd_pop = (state_r == S_IDLE) && cmd_valid &&
              (!cmd.last || !out_valid_r || out_ready);
  end

  always_comb begin
    state_nxt = state_r;  sweep_nxt = sweep_r;  limit_nxt = limit_r;
    cur_nxt = cur_r;  par_nxt = par_r;  cend_nxt = cend_r;  fail_nxt = fail_r;
    plane_nxt = plane_r;  pos_nxt = pos_r;  best_nxt = best_r;
    ntot_nxt = ntot_r;  wtot_nxt = wtot_r;
    out_valid_nxt = out_valid_r && !out_ready;
    res_nxt = res_r;
    entry = row_r[cmd_r.lane];
    next_node = '0;  next_end = 1'b0;
    alloc = 1'b0;  step = 1'b0;  set_end = 1'b0;  ok = 1'b0;  mlen = '0;
    pos_inc = (pos_r < LW'(MAX_LENGTH)) ? pos_r + 1'b1 : pos_r;
    best32 = '0;  wt32 = '0;  nt32 = '0;
    wr_row = par_r;  wr_lane = plane_r;  wr_node = cur_r;

    case (state_r)
      S_CLR: begin
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == limit_r) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (cmd_pop) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        if (cmd_r.walk && !fail_r) begin
          if (cmd_r.bad_char) begin
            fail_nxt = 1'b1;
          end else if (entry[NW-1:0] != '0) begin
            step = 1'b1;  next_node = entry[NW-1:0];  next_end = entry[NW];
          end else if (cmd_r.func == twt_pkg::FN_INSERT && ntot_r < NCW'(NODE_POOL)) begin
            alloc = 1'b1;  next_node = ntot_r[NW-1:0];
          end else begin
            fail_nxt = 1'b1;
          end
        end
        if (step || alloc) begin
          par_nxt = cur_r;  plane_nxt = cmd_r.lane;
          cur_nxt = next_node;  cend_nxt = next_end;  pos_nxt = pos_inc;
          if (cmd_r.func == twt_pkg::FN_LONGEST && next_end) best_nxt = pos_inc;
        end
        if (alloc) ntot_nxt = ntot_r + 1'b1;
        // link to the node reached, taken before the walker is cleared
        wr_row = par_nxt;  wr_lane = plane_nxt;  wr_node = cur_nxt;
        if (cmd_r.last) begin
          case (cmd_r.func)
            twt_pkg::FN_INSERT: begin
              ok = !fail_nxt && (pos_nxt != '0);
              set_end = ok && !cend_nxt;
              if (set_end) wtot_nxt = wtot_r + 1'b1;
            end
            twt_pkg::FN_SEARCH:  ok = !fail_nxt && cend_nxt;
            twt_pkg::FN_PREFIX:  ok = !fail_nxt;
            twt_pkg::FN_LONGEST: begin
              best32 = 32'(best_nxt);
              mlen = (best32 > 32'd255) ? 8'd255 : best32[7:0];
              ok = (mlen != 8'd0);
            end
            twt_pkg::FN_CLEAR: begin
              ok = 1'b1;
              wtot_nxt = '0;
              ntot_nxt = NCW'(1);
              limit_nxt = NW'(ntot_r - 1'b1);
              sweep_nxt = '0;
              state_nxt = S_CLR;
            end
            default: ok = 1'b0;
          endcase
          cur_nxt = '0;  par_nxt = '0;  plane_nxt = '0;  cend_nxt = 1'b0;
          fail_nxt = 1'b0;  pos_nxt = '0;  best_nxt = '0;
          wt32 = 32'(wtot_nxt);
          nt32 = 32'(ntot_nxt);
          out_valid_nxt = 1'b1;
          res_nxt.ok = ok;
          res_nxt.match_length = mlen;
          res_nxt.words_stored = (wt32 > 32'd1023) ? 10'd1023 : wt32[9:0];
          res_nxt.nodes_used   = (nt32 > 32'd2047) ? 11'd2047 : nt32[10:0];
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    wr_en = alloc || set_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;  sweep_r <= '0;  limit_r <= NW'(NODE_POOL - 1);
      cur_r <= '0;  par_r <= '0;  plane_r <= '0;  cend_r <= 1'b0;  fail_r <= 1'b0;
      pos_r <= '0;  best_r <= '0;  ntot_r <= NCW'(1);  wtot_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;  sweep_r <= sweep_nxt;  limit_r <= limit_nxt;
      cur_r <= cur_nxt;  par_r <= par_nxt;  plane_r <= plane_nxt;
      cend_r <= cend_nxt;  fail_r <= fail_nxt;
      pos_r <= pos_nxt;  best_r <= best_nxt;  ntot_r <= ntot_nxt;  wtot_r <= wtot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (cmd_pop) cmd_r <= cmd;
  end

  // node memory: row read, single-lane write, whole-row clear
  always_ff @(posedge clk) begin
    if (cmd_pop) row_r <= mem[cur_r];
    if (state_r == S_CLR) mem[sweep_r] <= '0;
    else if (wr_en) mem[wr_row][wr_lane] <= {set_end, wr_node};
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

  a_pool: assert property (@(posedge clk) disable iff (!rst_n)
    ntot_r <= NCW'(NODE_POOL) && ntot_r != '0)
    else $error("node count out of range");
  a_wr_exec: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> state_r == S_EXEC)
    else $error("memory write outside execute");
  a_pop_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |=> state_r == S_EXEC)
    else $error("popped item not executed");
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && cmd_r.last) |-> !out_valid_r)
    else $error("result register overwritten");

endmodule
`default_nettype wire

/* sv/trie_word_table_unit.sv */
`default_nettype none
// trie word table: words over a..z arrive one letter per transfer on the in_
// channel (func, letter, has_letter, last); the transfer with last high closes
// the word and yields one result transfer on the out_ channel (ok,
// match_length, words_stored, nodes_used). funcs: insert, search, prefix
// test, longest stored prefix, clear.
// a front stage classifies each letter and drops it into a small queue, so
// input transfers keep flowing while the engine works or the receiver stalls
// the engine takes one item at a time: the registered read of the current
// node's row (all 26 child links in one memory word), then the step that picks
// the child and possibly writes a new link or end flag
// out_valid rises once the last letter has passed through the queue, the row read
// and the execute step; a stalled out_ready holds the result register, the engine
// stops only before the next word end, and the queue then fills and drops in_ready
// after reset the engine sweeps the whole node memory, one row a cycle;
// a clear sweeps only the rows in use
// input transfers are queued during both sweeps
module trie_word_table_unit #(
  parameter int NODE_POOL  = twt_pkg::NODE_POOL_DEF,
  parameter int MAX_LENGTH = twt_pkg::MAX_LENGTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_func,
  input  wire logic [7:0]  in_letter,
  input  wire logic        in_has_letter,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_ok,
  output logic [7:0]       out_match_length,
  output logic [9:0]       out_words_stored,
  output logic [10:0]      out_nodes_used
);

  twt_pkg::cmd_t q_in, q_out;
  twt_pkg::res_t res;
  logic push, q_full, q_not_empty, pop;

  twt_front u_front (
    .in_valid, .in_ready, .in_func, .in_letter, .in_has_letter, .in_last,
    .push, .cmd(q_in), .q_full
  );

  twt_fifo u_fifo (
    .clk, .rst_n, .push, .wdata(q_in), .full(q_full),
    .pop, .rdata(q_out), .not_empty(q_not_empty)
  );

  twt_back #(.NODE_POOL(NODE_POOL), .MAX_LENGTH(MAX_LENGTH)) u_back (
    .clk, .rst_n, .cmd(q_out), .cmd_valid(q_not_empty), .cmd_pop(pop),
    .out_valid, .out_ready, .res
  );

  // result fields
  assign out_ok           = res.ok;
  assign out_match_length = res.match_length;
  assign out_words_stored = res.words_stored;
  assign out_nodes_used   = res.nodes_used;

endmodule
`default_nettype wire
